/* hw/rtl/pcd_pkg.sv */
// Package for the page coherence directory: states, opcodes, status codes,
// register indexes and shared sizing constants. No dependencies.
`default_nettype none
package pcd_pkg;
  localparam int NUM_PAGES_DEF  = 1024;
  localparam int MAX_AGENTS_DEF = 8;
  localparam int AGW = 3;

  typedef enum logic [2:0] {
    ST_I = 3'd0, ST_S = 3'd1, ST_E = 3'd2, ST_M = 3'd3,
    ST_TS = 3'd4, ST_TE = 3'd5, ST_TM = 3'd6, ST_X = 3'd7
  } cstate_t;

  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_RDWR  = 3'd1;
  localparam logic [2:0] OP_FLUSH = 3'd2;
  localparam logic [2:0] OP_DONE  = 3'd3;
  localparam logic [2:0] OP_REG   = 3'd4;

  localparam logic [2:0] STS_NONE    = 3'd0;
  localparam logic [2:0] STS_COPY    = 3'd1;
  localparam logic [2:0] STS_ONGOING = 3'd2;
  localparam logic [2:0] STS_NOSRC   = 3'd3;
  localparam logic [2:0] STS_BADAG   = 3'd4;

  localparam logic [1:0] REG_AGENTS = 2'd0;
  localparam logic [1:0] REG_IMPL   = 2'd1;
  localparam logic [1:0] REG_ONGO   = 2'd2;

  typedef struct packed {
    logic [2:0] status;
    logic       copy_valid;
    logic [2:0] copy_source;
    logic [2:0] copy_dest;
    logic       must_wait;
    logic       sync_ongoing;
    logic [7:0] finalize_mask;
    logic [7:0] invalidate_mask;
    logic [2:0] new_state;
  } result_t;

  function automatic logic [2:0] settle(input logic [2:0] s);
    return (s >= ST_TS && s <= ST_TM) ? s - 3'd3 : s;
  endfunction
  function automatic logic in_tr(input logic [2:0] s);
    return s >= ST_TS && s <= ST_TM;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/pcd_mem.sv */
// Directory state memory: one word of agent states per page, registered read.
// Depends on pcd_pkg.
`default_nettype none
module pcd_mem #(
  parameter int NUM_PAGES = 1024,
  parameter int WIDTH = 24
) (
  input  wire logic clk,
  input  wire logic                         re,
  input  wire logic [$clog2(NUM_PAGES)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata,
  input  wire logic                         we,
  input  wire logic [$clog2(NUM_PAGES)-1:0] waddr,
  input  wire logic [WIDTH-1:0]             wdata
);
  import pcd_pkg::*;
  logic [WIDTH-1:0] mem [NUM_PAGES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/pcd_update.sv */
// Combinational next-entry and result computation for one command.
// Depends on pcd_pkg.
`default_nettype none
module pcd_update #(
  parameter int MAX_AGENTS = 8
) (
  input  wire logic [3*MAX_AGENTS-1:0] cur,
  input  wire logic [2:0]              opcode,
  input  wire logic [2:0]              agent_id,
  input  wire logic [2:0]              home_agent,
  input  wire logic [3:0]              n_eff,
  input  wire logic [7:0]              impl_mask,
  input  wire logic [7:0]              ongo_mask,
  output logic [3*MAX_AGENTS-1:0]      nxt,
  output logic                         wr,
  output pcd_pkg::result_t             res
);
  import pcd_pkg::*;
  localparam int NA = (MAX_AGENTS < 8) ? MAX_AGENTS : 8;

  logic [2:0] st [8];
  logic [2:0] s, rs, tgt;
  logic       found;
  logic [2:0] src;

  always_comb begin
    for (int i = 0; i < 8; i++)
      st[i] = (i < NA) ? cur[3*i +: 3] : ST_I;
    nxt = cur;
    wr = 1'b0;
    res = '0;
    found = 1'b0;
    src = '0;
    s = '0;
    rs = '0;
    tgt = (opcode == OP_FLUSH || opcode == OP_REG) ? home_agent : agent_id;
    if (opcode > OP_REG) begin
      res.status = STS_NONE;
    end else if ({1'b0, tgt} >= n_eff) begin
      res.status = STS_BADAG;
    end else begin
      case (opcode)
        OP_READ, OP_RDWR: begin
          s = st[agent_id];
          res.new_state = s;
          if (in_tr(s)) begin
            res.status = STS_ONGOING;
            if (ongo_mask[agent_id]) res.sync_ongoing = 1'b1;
            else res.must_wait = 1'b1;
          end else if (opcode == OP_READ && s == ST_I) begin
            for (int r = 7; r >= 0; r--) begin
              if (r < n_eff && r != agent_id &&
                  st[r] != ST_I && st[r] != ST_TS) begin
                found = 1'b1;
                src = r[2:0];
              end
            end
            if (!found) res.status = STS_NOSRC;
            else begin
              rs = st[src];
              if (in_tr(rs)) res.finalize_mask[src] = 1'b1;
              rs = settle(rs);
              if (rs == ST_E || rs == ST_M) rs = ST_S;
              nxt[3*src +: 3] = rs;
              nxt[3*agent_id +: 3] = ST_TS;
              res.new_state = ST_TS;
              res.status = STS_COPY;
              res.copy_valid = 1'b1;
              res.copy_source = src;
              res.copy_dest = agent_id;
              res.must_wait = ~impl_mask[agent_id];
              wr = 1'b1;
            end
          end else if (opcode == OP_RDWR && (s == ST_I || s == ST_S)) begin
            for (int r = 7; r >= 0; r--) begin
              if (r < n_eff && r != agent_id && st[r] != ST_I) begin
                found = 1'b1;
                src = r[2:0];
              end
            end
            if (!found && s == ST_I) res.status = STS_NOSRC;
            else begin
              for (int r = 0; r < 8; r++) begin
                if (r < n_eff && r != agent_id && st[r] != ST_I) begin
                  if (in_tr(st[r])) res.finalize_mask[r] = 1'b1;
                  res.invalidate_mask[r] = 1'b1;
                  nxt[3*r +: 3] = ST_I;
                end
              end
              if (s == ST_I) begin
                res.status = STS_COPY;
                res.copy_valid = 1'b1;
                res.copy_source = src;
                res.copy_dest = agent_id;
                res.must_wait = ~impl_mask[agent_id];
              end
              res.new_state = (s == ST_S) ? ST_M : ST_TM;
              nxt[3*agent_id +: 3] = res.new_state;
              wr = 1'b1;
            end
          end
        end
        OP_FLUSH: begin
          s = st[home_agent];
          if (in_tr(s)) res.finalize_mask[home_agent] = 1'b1;
          s = settle(s);
          if (s == ST_I) begin
            for (int r = 7; r >= 0; r--) begin
              if (r < n_eff && r != home_agent && st[r] != ST_I) begin
                found = 1'b1;
                src = r[2:0];
              end
            end
          end
          if (s == ST_I && !found) begin
            res.status = STS_NOSRC;
            res.new_state = s;
            nxt[3*home_agent +: 3] = s;
          end else begin
            if (s == ST_I) begin
              if (in_tr(st[src])) res.finalize_mask[src] = 1'b1;
              res.status = STS_COPY;
              res.copy_valid = 1'b1;
              res.copy_source = src;
              res.copy_dest = home_agent;
              res.must_wait = 1'b1;
              res.new_state = ST_TE;
            end else res.new_state = ST_E;
            for (int r = 0; r < 8; r++) begin
              if (r < n_eff && r != home_agent) begin
                if (st[r] != ST_I) res.invalidate_mask[r] = 1'b1;
                nxt[3*r +: 3] = ST_I;
              end
            end
            nxt[3*home_agent +: 3] = res.new_state;
          end
          wr = 1'b1;
        end
        OP_DONE: begin
          s = st[agent_id];
          if (in_tr(s)) res.finalize_mask[agent_id] = 1'b1;
          res.new_state = settle(s);
          nxt[3*agent_id +: 3] = settle(s);
          wr = 1'b1;
        end
        default: begin
          for (int r = 0; r < 8; r++)
            if (r < n_eff && r != home_agent && st[r] != ST_I)
              res.invalidate_mask[r] = 1'b1;
          nxt = '0;
          nxt[3*home_agent +: 3] = ST_E;
          res.new_state = ST_E;
          wr = 1'b1;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/page_coherence_directory.sv */
// Page coherence directory, top level.
// Flow: an accepted command and the read of its page entry are registered; the result
// word is then registered while the updated entry is written back. A new command is
// accepted only after that write-back (busy is high meanwhile). After reset a clearing
// pass sets every page invalid, busy held high meanwhile; results cannot be stalled.
`default_nettype none
module page_coherence_directory #(
  parameter int NUM_PAGES  = pcd_pkg::NUM_PAGES_DEF,
  parameter int MAX_AGENTS = pcd_pkg::MAX_AGENTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_opcode,
  input  wire logic [2:0] in_agent_id,
  input  wire logic [9:0] in_page_index,
  input  wire logic [2:0] in_home_agent,
  output logic            out_strobe,
  output logic [2:0]      out_status,
  output logic            out_copy_valid,
  output logic [2:0]      out_copy_source,
  output logic [2:0]      out_copy_dest,
  output logic            out_must_wait,
  output logic            out_sync_ongoing,
  output logic [7:0]      out_finalize_mask,
  output logic [7:0]      out_invalidate_mask,
  output logic [2:0]      out_new_state,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import pcd_pkg::*;

  localparam int PW = $clog2(NUM_PAGES);
  localparam int EW = 3 * MAX_AGENTS;

  // config registers
  logic [3:0] agents_r;
  logic [7:0] impl_r, ongo_r;
  logic [3:0] n_eff;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agents_r <= 4'd2;
      impl_r <= '0;
      ongo_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_AGENTS: agents_r <= pwdata[3:0];
        REG_IMPL:   impl_r <= pwdata[7:0];
        REG_ONGO:   ongo_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_AGENTS: prdata = {28'd0, agents_r};
      REG_IMPL:   prdata = {24'd0, impl_r};
      REG_ONGO:   prdata = {24'd0, ongo_r};
      default:    prdata = '0;
    endcase
  end
  always_comb begin
    if (agents_r < 4'd2) n_eff = 4'd2;
    else if ({28'd0, agents_r} > MAX_AGENTS) n_eff = 4'(MAX_AGENTS);
    else n_eff = agents_r;
  end

  // sequencer: clearing pass, then read stage and write-back stage
  logic          clr_r, clr_nxt;
  logic [PW:0]   clr_cnt_r, clr_cnt_nxt;
  logic          rd_r, rd_nxt;
  logic [2:0]    op_r, ag_r, hm_r;
  logic [PW-1:0] pg_r;
  logic          oor_r;
  logic          accept;
  logic [EW-1:0] rdata, nxt_ent;
  logic          upd_wr;
  result_t       res;
  logic          we;
  logic [PW-1:0] waddr;
  logic [EW-1:0] wdata;

  assign busy = clr_r | rd_r;
  assign accept = start & ~busy;

  always_comb begin
    clr_nxt = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == (PW+1)'(NUM_PAGES - 1)) clr_nxt = 1'b0;
    end
    rd_nxt = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
      rd_r <= 1'b0;
    end else begin
      clr_r <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
      ag_r <= in_agent_id;
      hm_r <= in_home_agent;
      pg_r <= in_page_index[PW-1:0];
      oor_r <= ({22'd0, in_page_index} >= NUM_PAGES);
    end
  end

  pcd_mem #(.NUM_PAGES(NUM_PAGES), .WIDTH(EW)) u_mem (
    .clk(clk), .re(accept), .raddr(in_page_index[PW-1:0]), .rdata(rdata),
    .we(we), .waddr(waddr), .wdata(wdata)
  );

  // out-of-range pages act like an unknown opcode
  pcd_update #(.MAX_AGENTS(MAX_AGENTS)) u_upd (
    .cur(rdata), .opcode(oor_r ? 3'd7 : op_r), .agent_id(ag_r),
    .home_agent(hm_r), .n_eff(n_eff), .impl_mask(impl_r), .ongo_mask(ongo_r),
    .nxt(nxt_ent), .wr(upd_wr), .res(res)
  );

  assign we    = clr_r | (rd_r & upd_wr);
  assign waddr = clr_r ? clr_cnt_r[PW-1:0] : pg_r;
  assign wdata = clr_r ? '0 : nxt_ent;

  // registered result word, one cycle wide
  logic    ostb_r;
  result_t ores_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ostb_r <= 1'b0;
    else ostb_r <= rd_r;
  end
  always_ff @(posedge clk) begin
    if (rd_r) ores_r <= res;
  end
  assign out_strobe          = ostb_r;
  assign out_status          = ores_r.status;
  assign out_copy_valid      = ores_r.copy_valid;
  assign out_copy_source     = ores_r.copy_source;
  assign out_copy_dest       = ores_r.copy_dest;
  assign out_must_wait       = ores_r.must_wait;
  assign out_sync_ongoing    = ores_r.sync_ongoing;
  assign out_finalize_mask   = ores_r.finalize_mask;
  assign out_invalidate_mask = ores_r.invalidate_mask;
  assign out_new_state       = ores_r.new_state;

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe) else $error("missing result");
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !accept) else $error("accept during clear");
  a_copy_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_copy_valid) |-> (out_copy_source == 3'd0 && out_copy_dest == 3'd0))
    else $error("copy fields set without copy");
`endif
endmodule
`default_nettype wire
